// ===== rtl/sfir_pkg.sv =====
// Shared types, sizes and constants for the symmetric FIR load-cell filter.
// No dependencies; every other file refers to this package by scoped names.
package sfir_pkg;

  localparam int SampleW   = 24;
  localparam int CoeffW    = 16;
  localparam int FracBits  = 16;
  localparam int LineDepth = 16;
  localparam int NumCoeffs = LineDepth / 2;
  localparam int CoeffIdxW = $clog2(NumCoeffs);
  localparam int CfgIdxW   = CoeffIdxW + 1;
  // Number of delay-line entries that contribute to the sum (2 to 16).
  localparam int Taps      = 16;

  localparam int PairW = SampleW + 1;
  localparam int ProdW = PairW + CoeffW;
  localparam int Sum2W = ProdW + 1;
  localparam int Sum4W = ProdW + 2;
  localparam int AccW  = ProdW + 3;

  localparam logic [SampleW-1:0] SignFlip = SampleW'(1) << (SampleW - 1);
  localparam logic [SampleW-1:0] OutMax   = '1;

  typedef logic [SampleW-1:0] sample_t;
  typedef logic [CoeffW-1:0]  coeff_t;
  typedef coeff_t [NumCoeffs-1:0] coeff_arr_t;

  typedef enum logic [CfgIdxW-1:0] {
    COEFF_OUTER0 = 4'd0,
    COEFF_OUTER1 = 4'd1,
    COEFF_OUTER2 = 4'd2,
    COEFF_OUTER3 = 4'd3,
    COEFF_INNER3 = 4'd4,
    COEFF_INNER2 = 4'd5,
    COEFF_INNER1 = 4'd6,
    COEFF_INNER0 = 4'd7
  } cfg_reg_e;

  localparam coeff_arr_t CoeffReset = {
    16'd4153, 16'd4147, 16'd4137, 16'd4120,
    16'd4099, 16'd4071, 16'd4039, 16'd4002
  };

  // True when delay-line entry k takes part in the weighted sum.
  function automatic logic tap_used(input int k);
    return k < Taps;
  endfunction

endpackage

// ===== rtl/sfir_cfg.sv =====
// Coefficient register bank of the symmetric FIR filter: write decode and storage.
// Depends on sfir_pkg.
module sfir_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [sfir_pkg::CfgIdxW-1:0] cfg_index_i,
  input  sfir_pkg::coeff_t            cfg_data_i,
  output sfir_pkg::coeff_arr_t        coeff_o
);

  sfir_pkg::coeff_arr_t coeff_d, coeff_q;

  always_comb begin
    coeff_d = coeff_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i) inside
        sfir_pkg::COEFF_OUTER0, sfir_pkg::COEFF_OUTER1, sfir_pkg::COEFF_OUTER2,
        sfir_pkg::COEFF_OUTER3, sfir_pkg::COEFF_INNER3, sfir_pkg::COEFF_INNER2,
        sfir_pkg::COEFF_INNER1, sfir_pkg::COEFF_INNER0: begin
          coeff_d[cfg_index_i[sfir_pkg::CoeffIdxW-1:0]] = cfg_data_i;
        end
        // drop writes to unmapped indexes
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeff_q <= sfir_pkg::CoeffReset;
    end else begin
      coeff_q <= coeff_d;
    end
  end

  assign coeff_o = coeff_q;

endmodule

// ===== rtl/symmetric_fir_load_cell_filter_top.sv =====
// Top level of the symmetric 16-tap FIR filter for load-cell converter words.
// Depends on sfir_pkg and sfir_cfg.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o, raw_word_i) takes one 24-bit
//   two's-complement converter word per transaction. The top bit is inverted
//   and the sample enters a 16-entry delay line at the moment it is accepted.
//   Output channel (out_valid_o / out_ready_i) returns one transaction per
//   input: filtered_value_o = (sum of tap * Q0.16 weight) >> 16, clamped at
//   all ones, with saturated_o set when clamped.
//   Throughput: one transaction per cycle while the receiver keeps
//   out_ready_i high; the rate is set by the pipeline of pair pre-add,
//   eight parallel 25x16 multipliers and a two-level registered adder tree.
//   Each stage holds while its successor is full, so a stalled receiver
//   fills the pipeline (up to five transactions) before in_ready_o drops.
//   Configuration: cfg_we_i writes coefficient register cfg_index_i (0..7);
//   higher indexes are ignored. Write only while idle.
//   Reset: delay line cleared to zero, coefficients to their defaults,
//   pipeline empty.
module symmetric_fir_load_cell_filter_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [sfir_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [sfir_pkg::CoeffW-1:0]  cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [sfir_pkg::SampleW-1:0] raw_word_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [sfir_pkg::SampleW-1:0] filtered_value_o,
  output logic                         saturated_o
);

  localparam int NC = sfir_pkg::NumCoeffs;
  localparam int LD = sfir_pkg::LineDepth;

  sfir_pkg::coeff_arr_t coeff;

  sfir_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .coeff_o     (coeff)
  );

  // Stage enables: a stage loads when it is empty or its successor loads.
  logic en1, en2, en3, en4, en_out;
  logic v1_q, v2_q, v3_q, v4_q, out_valid_q;
  logic in_accept;

  assign en_out    = !out_valid_q || out_ready_i;
  assign en4       = !v4_q || en_out;
  assign en3       = !v3_q || en4;
  assign en2       = !v2_q || en3;
  assign en1       = !v1_q || en2;
  assign in_ready_o = en1;
  assign in_accept = in_valid_i && en1;

  // Delay line and pre-add of mirrored taps.
  sfir_pkg::sample_t line_d [LD];
  sfir_pkg::sample_t line_q [LD];
  logic [sfir_pkg::PairW-1:0] pair_d [NC];
  logic [sfir_pkg::PairW-1:0] pair_q [NC];

  always_comb begin
    line_d[0] = raw_word_i ^ sfir_pkg::SignFlip;
    for (int i = 1; i < LD; i++) begin
      line_d[i] = line_q[i-1];
    end
    for (int k = 0; k < NC; k++) begin
      pair_d[k] = (sfir_pkg::tap_used(k) ? {1'b0, line_d[k]} : '0)
                + (sfir_pkg::tap_used(LD - 1 - k) ? {1'b0, line_d[LD-1-k]} : '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LD; i++) begin
        line_q[i] <= '0;
      end
    end else if (in_accept) begin
      line_q <= line_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      pair_q <= pair_d;
    end
  end

  // Multiply each pair by its weight.
  logic [sfir_pkg::ProdW-1:0] prod_q [NC];

  always_ff @(posedge clk_i) begin
    if (en2) begin
      for (int k = 0; k < NC; k++) begin
        prod_q[k] <= sfir_pkg::ProdW'(pair_q[k]) * sfir_pkg::ProdW'(coeff[k]);
      end
    end
  end

  // Adder tree, one level per stage.
  logic [sfir_pkg::Sum2W-1:0] sum2_q [NC/2];
  logic [sfir_pkg::Sum4W-1:0] sum4_q [NC/4];

  always_ff @(posedge clk_i) begin
    if (en3) begin
      for (int k = 0; k < NC/2; k++) begin
        sum2_q[k] <= sfir_pkg::Sum2W'(prod_q[2*k]) + sfir_pkg::Sum2W'(prod_q[2*k+1]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      for (int k = 0; k < NC/4; k++) begin
        sum4_q[k] <= sfir_pkg::Sum4W'(sum2_q[2*k]) + sfir_pkg::Sum4W'(sum2_q[2*k+1]);
      end
    end
  end

  // Final add, scale and clamp.
  logic [sfir_pkg::AccW-1:0]    acc;
  logic                         sat_d, sat_q;
  logic [sfir_pkg::SampleW-1:0] value_d, value_q;

  assign acc     = sfir_pkg::AccW'(sum4_q[0]) + sfir_pkg::AccW'(sum4_q[1]);
  assign sat_d   = |acc[sfir_pkg::AccW-1:sfir_pkg::FracBits+sfir_pkg::SampleW];
  assign value_d = sat_d ? sfir_pkg::OutMax
                         : acc[sfir_pkg::FracBits+sfir_pkg::SampleW-1:sfir_pkg::FracBits];

  always_ff @(posedge clk_i) begin
    if (en_out) begin
      value_q <= value_d;
      sat_q   <= sat_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en1)    v1_q        <= in_valid_i;
      if (en2)    v2_q        <= v1_q;
      if (en3)    v3_q        <= v2_q;
      if (en4)    v4_q        <= v3_q;
      if (en_out) out_valid_q <= v4_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign filtered_value_o = value_q;
  assign saturated_o      = sat_q;

`ifndef ASSERT_OFF
  a_sat_clamps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |-> filtered_value_o == sfir_pkg::OutMax)
    else $error("saturated result not clamped to full scale");

  a_accept_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> v1_q)
    else $error("accepted transaction missing from first stage");

  a_line_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> line_q[0] == ($past(raw_word_i) ^ sfir_pkg::SignFlip)
                  && line_q[1] == $past(line_q[0]))
    else $error("delay line did not shift in the flipped sample");

  a_line_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_accept |=> line_q[0] == $past(line_q[0]))
    else $error("delay line moved without a transaction");

  a_stage4_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q && !en4 |=> v4_q && sum4_q[0] == $past(sum4_q[0])
                     && sum4_q[1] == $past(sum4_q[1]))
    else $error("stalled tree stage overwritten");
`endif

endmodule

// ===== tb/symmetric_fir_load_cell_filter_top_test.sv =====
// Self-checking testbench for symmetric_fir_load_cell_filter_top: random and directed converter
// words with a cycle-free filter predictor, valid/ready idling and coefficient reloads.
// Depends on sfir_pkg and the RTL of the filter top level.
`timescale 1ns / 100ps

module symmetric_fir_load_cell_filter_top_test;

  localparam int CycleLimit = 200000;
  localparam int LongHold   = 300;
  localparam int DrainWait  = 16;

  typedef logic [sfir_pkg::CfgIdxW-1:0] cfg_idx_t;

  typedef struct packed {
    sfir_pkg::sample_t value;
    logic              sat;
  } filt_result_t;

  typedef enum {
    MIX_DEFAULT,
    MIX_FULL,
    MIX_ZERO,
    MIX_RANDOM,
    MIX_LOW,
    MIX_ONE_TAP
  } coeff_mix_e;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  cfg_idx_t          cfg_index_i = '0;
  sfir_pkg::coeff_t  cfg_data_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  sfir_pkg::sample_t raw_word_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  sfir_pkg::sample_t filtered_value_o;
  logic              saturated_o;

  // predictor state
  sfir_pkg::sample_t    tap_hist [sfir_pkg::LineDepth] = '{default: '0};
  sfir_pkg::coeff_arr_t coeff_bank = sfir_pkg::CoeffReset;

  sfir_pkg::sample_t raw_words_pending [$];
  filt_result_t      expected_outputs [$];

  int   mismatch_count = 0;
  int   cycle_count = 0;
  int   tx_gap_left = 0;
  int   rx_stall_left = 0;
  int   hold_left = 0;
  logic bursts_on = 1'b1;
  logic long_hold_req = 1'b0;
  logic long_hold_taken = 1'b0;
  filt_result_t want;

  symmetric_fir_load_cell_filter_top DUT (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i,
    .in_valid_i,
    .in_ready_o,
    .raw_word_i,
    .out_valid_o,
    .out_ready_i,
    .filtered_value_o,
    .saturated_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Advance the delay line by one sample and return the weighted, clamped sum.
  function automatic filt_result_t run_filter_step(sfir_pkg::sample_t raw);
    logic [63:0]  acc;
    logic [63:0]  scaled;
    int           mirror;
    filt_result_t res;
    for (int k = sfir_pkg::LineDepth - 1; k > 0; k--) tap_hist[k] = tap_hist[k-1];
    tap_hist[0] = raw ^ sfir_pkg::SignFlip;
    acc = '0;
    for (int k = 0; k < sfir_pkg::Taps; k++) begin
      mirror = (k < sfir_pkg::LineDepth - 1 - k) ? k : sfir_pkg::LineDepth - 1 - k;
      acc += 64'(tap_hist[k]) * 64'(coeff_bank[mirror]);
    end
    scaled = acc >> sfir_pkg::FracBits;
    if (scaled > 64'(sfir_pkg::OutMax)) begin
      res.value = sfir_pkg::OutMax;
      res.sat   = 1'b1;
    end else begin
      res.value = sfir_pkg::sample_t'(scaled);
      res.sat   = 1'b0;
    end
    return res;
  endfunction

  // Sender: hold the payload while stalled, otherwise idle or offer the next word.
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      expected_outputs.push_back(run_filter_step(raw_word_i));
    end
    if (!(in_valid_i && !in_ready_o)) begin
      if (tx_gap_left > 0) begin
        tx_gap_left--;
        in_valid_i <= 1'b0;
      end else if (raw_words_pending.size() > 0) begin
        in_valid_i <= 1'b1;
        raw_word_i <= raw_words_pending.pop_front();
        if (bursts_on && $urandom_range(0, 7) == 0) tx_gap_left = $urandom_range(1, 16);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: check each output transaction, then decide on ready for the next cycle.
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      if (expected_outputs.size() == 0) begin
        $error("unexpected output transaction: filtered_value=%0d saturated=%0b",
               filtered_value_o, saturated_o);
        mismatch_count++;
      end else begin
        want = expected_outputs.pop_front();
        if (filtered_value_o !== want.value) begin
          $error("filtered_value mismatch: expected %0d, actual %0d",
                 want.value, filtered_value_o);
          mismatch_count++;
        end
        if (saturated_o !== want.sat) begin
          $error("saturated mismatch: expected %0b, actual %0b", want.sat, saturated_o);
          mismatch_count++;
        end
      end
    end
    if (long_hold_req && !long_hold_taken) begin
      long_hold_taken = 1'b1;
      hold_left = LongHold;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (rx_stall_left > 0) begin
      rx_stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      if (bursts_on && $urandom_range(0, 7) == 0) rx_stall_left = $urandom_range(1, 16);
    end
  end

  task automatic write_reg(input cfg_idx_t idx, input sfir_pkg::coeff_t data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx < sfir_pkg::NumCoeffs) coeff_bank[idx] = data;
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (raw_words_pending.size() != 0 || in_valid_i || expected_outputs.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic load_coeffs(input coeff_mix_e mix);
    sfir_pkg::coeff_t val;
    int               hot;
    hot = $urandom_range(0, sfir_pkg::NumCoeffs - 1);
    for (int r = 0; r < sfir_pkg::NumCoeffs; r++) begin
      case (mix)
        MIX_DEFAULT: val = sfir_pkg::CoeffReset[r];
        MIX_FULL:    val = '1;
        MIX_ZERO:    val = '0;
        MIX_RANDOM:  val = sfir_pkg::coeff_t'($urandom);
        MIX_LOW:     val = sfir_pkg::coeff_t'($urandom_range(0, 4096));
        default:     val = (r == hot) ? '1 : '0;
      endcase
      write_reg(sfir_pkg::cfg_reg_e'(r), val);
    end
    // an index past the bank must leave it untouched
    write_reg(cfg_idx_t'($urandom_range(sfir_pkg::NumCoeffs, 2 ** sfir_pkg::CfgIdxW - 1)),
              sfir_pkg::coeff_t'($urandom));
  endtask

  task automatic push_random_words(input int count);
    sfir_pkg::sample_t w;
    int                run_len;
    int                pushed;
    pushed = 0;
    while (pushed < count) begin
      case ($urandom_range(0, 3))
        0: begin
          case ($urandom_range(0, 3))
            0:       w = '0;
            1:       w = '1;
            2:       w = ~sfir_pkg::SignFlip;
            default: w = sfir_pkg::SignFlip;
          endcase
          run_len = 1;
        end
        1: begin
          // constant stretch of up to a full line, of the largest sample or a random word
          w = ($urandom_range(0, 1) == 0) ? ~sfir_pkg::SignFlip
                                           : sfir_pkg::sample_t'($urandom);
          run_len = $urandom_range(2, sfir_pkg::LineDepth);
        end
        default: begin
          w = sfir_pkg::sample_t'($urandom);
          run_len = 1;
        end
      endcase
      repeat (run_len) begin
        if (pushed < count) begin
          raw_words_pending.push_back(w);
          pushed++;
        end
      end
    end
  endtask

  task automatic run_phase(input coeff_mix_e mix, input logic idling, input logic with_hold,
                           input int count);
    wait_drained();
    load_coeffs(mix);
    @(negedge clk_i);
    bursts_on = idling;
    if (with_hold) long_hold_req = 1'b1;
    push_random_words(count);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset weights: corner words, then a full line of the largest sample at unity gain
    raw_words_pending.push_back('0);
    raw_words_pending.push_back('1);
    raw_words_pending.push_back(sfir_pkg::SignFlip);
    raw_words_pending.push_back(~sfir_pkg::SignFlip);
    raw_words_pending.push_back(sfir_pkg::sample_t'(1));
    raw_words_pending.push_back(sfir_pkg::SignFlip | sfir_pkg::sample_t'(1));
    repeat (sfir_pkg::LineDepth) raw_words_pending.push_back(~sfir_pkg::SignFlip);

    // full-scale weights must clamp; writes past the bank must not alias onto it
    wait_drained();
    load_coeffs(MIX_FULL);
    write_reg(cfg_idx_t'(sfir_pkg::NumCoeffs), '0);
    write_reg('1, '0);
    @(negedge clk_i);
    repeat (3) raw_words_pending.push_back(~sfir_pkg::SignFlip);

    run_phase(MIX_ZERO,    1'b1, 1'b0, 80);
    run_phase(MIX_RANDOM,  1'b1, 1'b1, 90);
    run_phase(MIX_FULL,    1'b0, 1'b0, 80);
    run_phase(MIX_LOW,     1'b1, 1'b0, 90);
    run_phase(MIX_ONE_TAP, 1'b1, 1'b0, 80);
    run_phase(MIX_RANDOM,  1'b1, 1'b0, 90);
    run_phase(MIX_DEFAULT, 1'b1, 1'b0, 80);
    // closing stretch runs without idling
    run_phase(MIX_RANDOM,  1'b0, 1'b0, 110);

    wait_drained();
    repeat (DrainWait) @(negedge clk_i);
    if (mismatch_count == 0 && expected_outputs.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
